### hw/rtl/pee_pkg.sv
// Shared constants, codes and interface types of the prefix expression evaluator.
// Used by pee_divider and prefix_expression_evaluator_unit; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package pee_pkg;

  // Operand stack geometry.
  localparam int STACK_DEPTH = 16;
  localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  // Data path width and divider iteration counter width.
  localparam int DATA_W     = 32;
  localparam int DIV_CNT_W  = $clog2(DATA_W);

  // Token kinds.
  localparam logic [2:0] OP_NUMBER = 3'd0;
  localparam logic [2:0] OP_MUL    = 3'd1;
  localparam logic [2:0] OP_DIV    = 3'd2;
  localparam logic [2:0] OP_ADD    = 3'd3;
  localparam logic [2:0] OP_SUB    = 3'd4;

  // Result status codes.
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_MISSING  = 3'd1;
  localparam logic [2:0] ST_NOT_ONE  = 3'd2;
  localparam logic [2:0] ST_DIV_ZERO = 3'd3;
  localparam logic [2:0] ST_OVERFLOW = 3'd4;

  // Request from the sequencer to the divider.
  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } div_req_t;

  // Response from the divider.
  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

### hw/rtl/prefix_expression_evaluator_unit.sv
// Top level of the prefix expression evaluator: token sequencer, operand stack memory
// and result register. Depends on pee_pkg and instantiates pee_divider.
`timescale 1ns / 1ps
`default_nettype none

//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+------------------------------------------
//  in_     | input     | in_valid/in_stall  | operation, operand_value, last_token
//  out_    | output    | out_valid/out_stall| status, result_value
//
// A number token is pushed in the idle state. Add, subtract and multiply take three steps: accept
// with the stack read, compute, write back. A divide waits between compute and write back on the
// one-bit-per-cycle divider. A token marked last adds two steps to read the bottom
// entry of the stack and load the result register; the result register lets the next
// expression start while the result still waits to be taken.
// Reset is synchronous and active low; it empties the stack and clears the error.
// The stack memory itself is not cleared, as entries above the count are never read.
// A stalled result blocks only the next last token, in its final step.

module prefix_expression_evaluator_unit
  import pee_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,

  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [2:0]         in_operation,
  input  wire logic signed [31:0] in_operand_value,
  input  wire logic               in_last_token,

  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [2:0]              out_status,
  output logic signed [31:0]      out_result_value
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_DIV_WAIT,
    S_WRITE,
    S_FINAL,
    S_FREAD
  } state_t;

  // Sequencer state and its next values.
  state_t            state_r,      state_nxt;
  logic [CNT_W-1:0]  count_r,      count_nxt;
  logic [2:0]        err_r,        err_nxt;
  logic [2:0]        op_r,         op_nxt;
  logic              last_r,       last_nxt;
  logic [DATA_W-1:0] res_r,        res_nxt;
  logic              out_valid_r,  out_valid_nxt;
  logic [2:0]        out_status_r, out_status_nxt;
  logic [DATA_W-1:0] out_value_r,  out_value_nxt;

  // Operand stack memory with two registered read ports and one write port.
  logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
  logic [DATA_W-1:0] rd_a_r;
  logic [DATA_W-1:0] rd_b_r;
  logic [ADDR_W-1:0] rd_addr_a;
  logic [ADDR_W-1:0] rd_addr_b;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [DATA_W-1:0] mem_wdata;

  logic              accept;
  logic              out_free;
  logic [CNT_W-1:0]  count_m1;
  logic [CNT_W-1:0]  count_m2;
  logic [DATA_W-1:0] product;
  state_t            after_token;

  div_req_t          div_req;
  div_rsp_t          div_rsp;

  pee_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign count_m1 = count_r - CNT_W'(1);
  assign count_m2 = count_r - CNT_W'(2);

  // The top of the stack is the left operand, the entry below it the right one.
  assign product = rd_a_r * rd_b_r;

  always_comb begin
    // After a token is done, a last token goes on to produce the result.
    after_token = last_r ? S_FINAL : S_IDLE;

    state_nxt      = state_r;
    count_nxt      = count_r;
    err_nxt        = err_r;
    op_nxt         = op_r;
    last_nxt       = last_r;
    res_nxt        = res_r;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_valid_nxt  = out_valid_r && out_stall;

    rd_addr_a = count_m1[ADDR_W-1:0];
    rd_addr_b = count_m2[ADDR_W-1:0];
    mem_we    = 1'b0;
    mem_waddr = count_r[ADDR_W-1:0];
    mem_wdata = in_operand_value;

    div_req.start    = 1'b0;
    div_req.dividend = rd_a_r;
    div_req.divisor  = rd_b_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt   = in_operation;
          last_nxt = in_last_token;
          if (err_r != ST_OK || in_operation > OP_SUB) begin
            // A latched error or an unknown code leaves the stack alone.
            state_nxt = in_last_token ? S_FINAL : S_IDLE;
          end else if (in_operation == OP_NUMBER) begin
            if (count_r >= CNT_W'(STACK_DEPTH)) begin
              err_nxt = ST_OVERFLOW;
            end else begin
              mem_we    = 1'b1;
              count_nxt = count_r + 1'b1;
            end
            state_nxt = in_last_token ? S_FINAL : S_IDLE;
          end else if (count_r < CNT_W'(2)) begin
            err_nxt   = ST_MISSING;
            state_nxt = in_last_token ? S_FINAL : S_IDLE;
          end else begin
            // Both operands are read from the memory at this edge.
            state_nxt = S_READ;
          end
        end
      end
      S_READ: begin
        case (op_r)
          OP_MUL: begin
            res_nxt   = product;
            state_nxt = S_WRITE;
          end
          OP_DIV: begin
            if (rd_b_r == '0) begin
              err_nxt   = ST_DIV_ZERO;
              state_nxt = after_token;
            end else begin
              div_req.start = 1'b1;
              state_nxt     = S_DIV_WAIT;
            end
          end
          OP_ADD: begin
            res_nxt   = rd_a_r + rd_b_r;
            state_nxt = S_WRITE;
          end
          default: begin
            res_nxt   = rd_a_r - rd_b_r;
            state_nxt = S_WRITE;
          end
        endcase
      end
      S_DIV_WAIT: begin
        if (div_rsp.done) begin
          res_nxt   = div_rsp.quotient;
          state_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        // Two operands out, one result in, at the lower operand's place.
        mem_we    = 1'b1;
        mem_waddr = count_m2[ADDR_W-1:0];
        mem_wdata = res_r;
        count_nxt = count_m1;
        state_nxt = after_token;
      end
      S_FINAL: begin
        rd_addr_a = '0;
        state_nxt = S_FREAD;
      end
      S_FREAD: begin
        rd_addr_a = '0;
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (err_r != ST_OK) begin
            out_status_nxt = err_r;
            out_value_nxt  = '0;
          end else if (count_r == CNT_W'(1)) begin
            out_status_nxt = ST_OK;
            out_value_nxt  = rd_a_r;
          end else begin
            out_status_nxt = ST_NOT_ONE;
            out_value_nxt  = '0;
          end
          count_nxt = '0;
          err_nxt   = ST_OK;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      err_r       <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r         <= op_nxt;
    last_r       <= last_nxt;
    res_r        <= res_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
  end

  // Stack memory: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_mem[mem_waddr] <= mem_wdata;
    end
    rd_a_r <= stack_mem[rd_addr_a];
    rd_b_r <= stack_mem[rd_addr_b];
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_result_value = out_value_r;

  // The stack count never passes the depth of the memory.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  // The divider is never started on a zero divisor.
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> (div_req.divisor != '0))
    else $error("divider started on zero divisor");

  // An error result always carries a zero value.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_OK) |-> (out_value_r == '0))
    else $error("error result with nonzero value");

  // Delivering a result empties the stack and clears the error.
  a_final_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FREAD && out_free) |=> (count_r == '0 && err_r == ST_OK))
    else $error("state not cleared after result");

  // A result is loaded only while the output register is free.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> $stable(out_value_r) && $stable(out_status_r))
    else $error("pending result overwritten");

endmodule

`default_nettype wire

### hw/rtl/pee_divider.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on pee_pkg for the data width and the request and response types.
`timescale 1ns / 1ps
`default_nettype none

module pee_divider
  import pee_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  typedef enum logic [1:0] {
    D_IDLE,
    D_RUN,
    D_FIX
  } dstate_t;

  dstate_t              state_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DATA_W-1:0]    rem_r;
  logic [DATA_W-1:0]    quo_r;
  logic [DATA_W-1:0]    den_r;
  logic                 neg_r;
  logic                 done_r;

  logic [DATA_W:0]      rem_shift;
  logic [DATA_W:0]      diff;

  assign rem_shift = {rem_r, quo_r[DATA_W-1]};
  assign diff      = rem_shift - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        D_IDLE: begin
          if (req.start) begin
            // Work on magnitudes; the sign is put back at the end.
            den_r   <= req.divisor[DATA_W-1] ? (~req.divisor + 1'b1) : req.divisor;
            quo_r   <= req.dividend[DATA_W-1] ? (~req.dividend + 1'b1) : req.dividend;
            rem_r   <= '0;
            neg_r   <= req.dividend[DATA_W-1] ^ req.divisor[DATA_W-1];
            cnt_r   <= DIV_CNT_W'(DATA_W - 1);
            state_r <= D_RUN;
          end
        end
        D_RUN: begin
          if (!diff[DATA_W]) begin
            rem_r <= diff[DATA_W-1:0];
          end else begin
            rem_r <= rem_shift[DATA_W-1:0];
          end
          quo_r <= {quo_r[DATA_W-2:0], ~diff[DATA_W]};
          if (cnt_r == '0) begin
            state_r <= D_FIX;
          end else begin
            cnt_r <= cnt_r - 1'b1;
          end
        end
        D_FIX: begin
          quo_r   <= neg_r ? (~quo_r + 1'b1) : quo_r;
          done_r  <= 1'b1;
          state_r <= D_IDLE;
        end
        default: begin
          state_r <= D_IDLE;
        end
      endcase
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

`default_nettype wire

### tb/prefix_expression_evaluator_unit_tb.sv
// Self-checking testbench for prefix_expression_evaluator_unit: directed and random token streams
// are scored against an operand-stack predictor. Depends on pee_pkg and the unit under test.
`timescale 1ns / 1ps

module prefix_expression_evaluator_unit_tb
  import pee_pkg::*;
();

  // Token kinds 5 to 7 are not operations; the unit must let them pass without effect.
  localparam logic [2:0] OP_RSVD5 = 3'd5;
  localparam logic [2:0] OP_RSVD7 = 3'd7;

  localparam int IDLE_PERCENT  = 36;
  localparam int ITEM_TARGET   = 1400;
  // A divide holds the unit while the divider works through every quotient bit, and a stalled result
  // can hold it longer still, so a silent stretch far beyond that means the unit has hung.
  localparam int HANG_LIMIT    = 4000;
  localparam int DRAIN_CYCLES  = 64;

  typedef struct {
    logic [2:0]  status;
    logic [31:0] value;
  } eval_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [2:0]         in_operation = OP_NUMBER;
  logic signed [31:0] in_operand_value = '0;
  logic               in_last_token = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [2:0]         out_status;
  logic signed [31:0] out_result_value;

  // Predicted state of the evaluator, advanced once per accepted token.
  logic [31:0]  eval_stack [STACK_DEPTH];
  int           eval_depth = 0;
  logic [2:0]   eval_error = ST_OK;
  eval_result_t expected_results [$];

  bit idle_enable = 1'b1;
  int tokens_counted = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  prefix_expression_evaluator_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_operand_value (in_operand_value),
    .in_last_token    (in_last_token),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_result_value (out_result_value)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // The result side stalls at random, except during the back-to-back stretch.
  always @(posedge clk) begin
    out_stall <= idle_enable && ($urandom_range(99) < IDLE_PERCENT);
  end

  // Every result taken is scored against the oldest prediction.
  always @(posedge clk) begin
    eval_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: status %0d value %0d", out_status, out_result_value);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          mismatches++;
        end
        if (out_result_value !== want.value) begin
          $error("result_value: expected %0d, got %0d",
                 $signed(want.value), out_result_value);
          mismatches++;
        end
      end
    end
  end

  // A hang shows up as a long run of cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= HANG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Offers one token, waits for it to be taken, then advances the predicted stack.
  // Valid is lowered only on an idle cycle, so it never gets two updates in one step.
  task automatic send_token(input logic [2:0] op, input logic [31:0] value, input logic last);
    logic [31:0]  lhs;
    logic [31:0]  rhs;
    logic [31:0]  res;
    longint       quotient;
    eval_result_t done;
    while (idle_enable && ($urandom_range(99) < IDLE_PERCENT)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_operation     <= op;
    in_operand_value <= value;
    in_last_token    <= last;
    do @(posedge clk); while (in_stall);

    tokens_counted++;
    // Once an error is latched, the rest of the expression changes nothing.
    if (eval_error == ST_OK) begin
      if (op == OP_NUMBER) begin
        if (eval_depth >= STACK_DEPTH) begin
          eval_error = ST_OVERFLOW;
        end else begin
          eval_stack[eval_depth] = value;
          eval_depth++;
        end
      end else if (op <= OP_SUB) begin
        if (eval_depth < 2) begin
          eval_error = ST_MISSING;
        end else begin
          // The top of the stack is the left operand.
          lhs = eval_stack[eval_depth-1];
          rhs = eval_stack[eval_depth-2];
          if (op == OP_DIV && rhs == '0) begin
            eval_error = ST_DIV_ZERO;
          end else begin
            case (op)
              OP_MUL: res = lhs * rhs;
              OP_DIV: begin
                // Widened so that the most negative value over minus one wraps cleanly.
                quotient = longint'($signed(lhs)) / longint'($signed(rhs));
                res = quotient[31:0];
              end
              OP_ADD: res = lhs + rhs;
              default: res = lhs - rhs;
            endcase
            eval_stack[eval_depth-2] = res;
            eval_depth--;
          end
        end
      end
    end
    if (last) begin
      done.status = eval_error;
      done.value  = '0;
      if (eval_error == ST_OK) begin
        if (eval_depth == 1) begin
          done.value = eval_stack[0];
        end else begin
          done.status = ST_NOT_ONE;
        end
      end
      expected_results.insert(expected_results.size(), done);
      eval_depth = 0;
      eval_error = ST_OK;
    end
  endtask

  // Operands lean toward small numbers, zero and the extremes, where the corner cases live.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(7))
      0, 1, 2: return $urandom;
      3, 4: return $urandom_range(8) - 4;
      5: return $urandom_range(255);
      default: begin
        case ($urandom_range(4))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'hffff_ffff;
          3: return 32'h0000_0001;
          default: return '0;
        endcase
      end
    endcase
  endfunction

  // Emits a well-formed expression of num_count numbers, right to left, with an occasional
  // token of an unknown kind mixed in. The token that folds the stack to one value is last.
  task automatic send_expression(input int num_count);
    int       left;
    int       depth;
    logic [2:0] op;
    left  = num_count;
    depth = 0;
    while (left > 0 || depth > 1) begin
      if (left > 0 && (depth < 2 || (depth < STACK_DEPTH && $urandom_range(1) == 0))) begin
        left--;
        depth++;
        send_token(OP_NUMBER, pick_value(), left == 0 && depth == 1);
      end else begin
        depth--;
        op = 3'($urandom_range(OP_MUL, OP_SUB));
        send_token(op, $urandom, left == 0 && depth == 1);
      end
      if ((left > 0 || depth > 1) && $urandom_range(24) == 0) begin
        send_token(3'($urandom_range(OP_RSVD5, OP_RSVD7)), $urandom, 1'b0);
      end
    end
  endtask

  task automatic test_single_values();
    send_token(OP_NUMBER, 32'h8000_0000, 1'b1);
    send_token(OP_NUMBER, 32'h7fff_ffff, 1'b1);
    send_token(OP_NUMBER, '0, 1'b1);
  endtask

  task automatic test_arithmetic();
    // The most negative value divided by minus one wraps back to itself.
    send_token(OP_NUMBER, 32'hffff_ffff, 1'b0);
    send_token(OP_NUMBER, 32'h8000_0000, 1'b0);
    send_token(OP_DIV, $urandom, 1'b1);
    // (max + 1) * 7 with wrap on both steps, then 10 - 3 with the operand order checked.
    send_token(OP_NUMBER, 32'd7, 1'b0);
    send_token(OP_NUMBER, 32'd1, 1'b0);
    send_token(OP_NUMBER, 32'h7fff_ffff, 1'b0);
    send_token(OP_ADD, $urandom, 1'b0);
    send_token(OP_MUL, $urandom, 1'b1);
    send_token(OP_NUMBER, 32'd3, 1'b0);
    send_token(OP_NUMBER, 32'd10, 1'b0);
    send_token(OP_SUB, $urandom, 1'b1);
  endtask

  task automatic test_error_cases();
    // Divide by zero.
    send_token(OP_NUMBER, '0, 1'b0);
    send_token(OP_NUMBER, 32'd5, 1'b0);
    send_token(OP_DIV, $urandom, 1'b1);
    // Missing operand on an empty stack, marked last.
    send_token(OP_ADD, $urandom, 1'b1);
    // Missing operand stays latched while later tokens arrive.
    send_token(OP_MUL, $urandom, 1'b0);
    send_token(OP_NUMBER, 32'd1, 1'b1);
    // Two values left at the end.
    send_token(OP_NUMBER, 32'd1, 1'b0);
    send_token(OP_NUMBER, 32'd2, 1'b1);
    // An unknown kind ends an empty expression, and is skipped inside a valid one.
    send_token(OP_RSVD7, $urandom, 1'b1);
    send_token(OP_NUMBER, 32'd4, 1'b0);
    send_token(OP_RSVD5, $urandom, 1'b1);
  endtask

  task automatic test_stack_overflow();
    // The push past a full stack latches the overflow.
    for (int i = 0; i <= STACK_DEPTH; i++) begin
      send_token(OP_NUMBER, pick_value(), i == STACK_DEPTH);
    end
  endtask

  task automatic test_back_to_back();
    idle_enable = 1'b0;
    repeat (20) begin
      send_expression($urandom_range(1, 6));
    end
    idle_enable = 1'b1;
  endtask

  task automatic test_random_expressions();
    int len;
    while (tokens_counted < ITEM_TARGET) begin
      case ($urandom_range(9))
        0: begin
          // Token soup: any kind, any order, so errors of every sort come up.
          len = $urandom_range(1, 10);
          for (int i = 0; i < len; i++) begin
            send_token(3'($urandom_range(OP_NUMBER, OP_RSVD7)), pick_value(), i == len - 1);
          end
        end
        1: begin
          // Deep pushes around the stack limit, overflowing some of the time.
          len = $urandom_range(STACK_DEPTH - 1, STACK_DEPTH + 2);
          for (int i = 0; i < len; i++) begin
            send_token(OP_NUMBER, pick_value(), i == len - 1);
          end
        end
        2: send_expression($urandom_range(9, STACK_DEPTH + 4));
        default: send_expression($urandom_range(1, 8));
      endcase
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_single_values();
    test_arithmetic();
    test_error_cases();
    test_stack_overflow();
    test_back_to_back();
    test_random_expressions();

    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
